// ===== hdl/bfb_pkg.sv =====
// ---------------------------------------------------------------------------
// bfb_pkg
// Shared constants, opcodes, controller/datapath interface types and the
// trailing-zero count used by the bitmap find-bit engine.
// ---------------------------------------------------------------------------
package bfb_pkg;

  // Fixed geometry of the bitmap and of the request fields
  localparam int WORD_BITS     = 64;
  localparam int NUM_WORDS_DEF = 64;
  localparam int POS_W         = 13;
  localparam int OFS_W         = 6;
  localparam int WIDX_W        = 6;
  localparam int START_W       = 12;
  localparam int OP_W          = 2;
  localparam int WCNT_W        = POS_W - OFS_W;
  localparam int SIZE_RST      = 4096;

  // Opcodes
  localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND_FIRST = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND_SET   = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND_ZERO  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_we;    // clearing pass: zero one word
    logic take;      // request accepted this cycle
    logic rd_next;   // fetch the following word
    logic res_none;  // nothing found: result is the size
    logic cur_load;  // capture the non-empty word
    logic res_hit;   // resolve the bit position of the captured word
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic start_past;
    logic cur_nz;
    logic next_past;
    logic out_free;
  } sts_t;

  // Trailing-zero count of a non-zero word, binary halving
  function automatic logic [OFS_W-1:0] tz64(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [OFS_W-1:0]     n;
    v = w;
    n = '0;
    if (v[31:0] == 32'd0) begin
      n[5] = 1'b1;
      v    = v >> 32;
    end
    if (v[15:0] == 16'd0) begin
      n[4] = 1'b1;
      v    = v >> 16;
    end
    if (v[7:0] == 8'd0) begin
      n[3] = 1'b1;
      v    = v >> 8;
    end
    if (v[3:0] == 4'd0) begin
      n[2] = 1'b1;
      v    = v >> 4;
    end
    if (v[1:0] == 2'd0) begin
      n[1] = 1'b1;
      v    = v >> 2;
    end
    if (v[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

// ===== hdl/bitmap_find_bit_engine_unit.sv =====
// ---------------------------------------------------------------------------
// bitmap_find_bit_engine_unit
// Bitmap of 64-bit words with word writes and find-first-set,
// find-next-set and find-next-zero searches.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries opcode, word index,
//   word data and start offset. Result channel (out_valid_o / out_stall_i)
//   returns one bit position and found flag per request, in order.
//   cfg_valid_i / cfg_ready_o writes bitmap_size; ready is always high.
//   Writes are to be made only while no request is in flight; the block
//   itself does not enforce this. One request is processed at a time. A
//   write or a start at or beyond the size goes from intake straight to
//   the result hand-off; a search scans 1 to NUM_WORDS words, the single
//   read port of the word memory delivering one word per cycle, and one
//   that finds a bit then resolves its position before the result is
//   loaded into the output register. The next request can be accepted in
//   the cycle after the result is loaded.
//   After reset a clearing pass zeroes every word of the word memory,
//   during which in_stall_o stays high.
//   A stalled result holds in the output register; the next request is
//   accepted meanwhile and its result waits until the register frees up.
// ---------------------------------------------------------------------------
module bitmap_find_bit_engine_unit #(
  parameter int NUM_WORDS = bfb_pkg::NUM_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfb_pkg::POS_W-1:0]     cfg_bitmap_size_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bfb_pkg::OP_W-1:0]      opcode_i,
  input  logic [bfb_pkg::WIDX_W-1:0]    word_index_i,
  input  logic [bfb_pkg::WORD_BITS-1:0] word_data_i,
  input  logic [bfb_pkg::START_W-1:0]   start_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bfb_pkg::POS_W-1:0]     bit_position_o,
  output logic                          found_o
);

  bfb_pkg::cmd_t cmd;
  bfb_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  bfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  bfb_dpath #(
    .NUM_WORDS (NUM_WORDS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_bitmap_size_i (cfg_bitmap_size_i),
    .opcode_i          (opcode_i),
    .word_index_i      (word_index_i),
    .word_data_i       (word_data_i),
    .start_offset_i    (start_offset_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .bit_position_o    (bit_position_o),
    .found_o           (found_o)
  );

endmodule

// ===== hdl/bfb_ctrl.sv =====
// ---------------------------------------------------------------------------
// bfb_ctrl
// Sequencer for the find-bit engine: clearing pass after reset, request
// intake, word-by-word scan, bit resolution and result hand-off.
// ---------------------------------------------------------------------------
module bfb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bfb_pkg::sts_t sts_i,
  output bfb_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FOUND = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = (sts_i.is_write || sts_i.start_past) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts_i.cur_nz) begin
          cmd_o.cur_load = 1'b1;
          state_d        = ST_FOUND;
        end else if (sts_i.next_past) begin
          cmd_o.res_none = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      ST_FOUND: begin
        cmd_o.res_hit = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/bfb_dpath.sv =====
// ---------------------------------------------------------------------------
// bfb_dpath
// Datapath of the find-bit engine: bitmap word memory, size register, scan
// pointer, trailing-zero resolution and the output register.
// ---------------------------------------------------------------------------
module bfb_dpath #(
  parameter int NUM_WORDS = bfb_pkg::NUM_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bfb_pkg::cmd_t                   cmd_i,
  output bfb_pkg::sts_t                   sts_o,
  input  logic                            cfg_valid_i,
  input  logic [bfb_pkg::POS_W-1:0]       cfg_bitmap_size_i,
  input  logic [bfb_pkg::OP_W-1:0]        opcode_i,
  input  logic [bfb_pkg::WIDX_W-1:0]      word_index_i,
  input  logic [bfb_pkg::WORD_BITS-1:0]   word_data_i,
  input  logic [bfb_pkg::START_W-1:0]     start_offset_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [bfb_pkg::POS_W-1:0]       bit_position_o,
  output logic                            found_o
);

  localparam int WB     = bfb_pkg::WORD_BITS;
  localparam int PW     = bfb_pkg::POS_W;
  localparam int OW     = bfb_pkg::OFS_W;
  localparam int WW     = bfb_pkg::WCNT_W;
  localparam int AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TOTAL  = NUM_WORDS * WB;
  localparam logic [PW-1:0] ESZ_RST =
    (bfb_pkg::SIZE_RST > TOTAL) ? PW'(TOTAL) : PW'(bfb_pkg::SIZE_RST);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  logic [WB-1:0]   mem [NUM_WORDS];
  logic [WB-1:0]   rdata_q;
  logic [PW-1:0]   esz_q;
  logic [AW-1:0]   clr_cnt_q;
  logic [WW-1:0]   wcnt_q;
  logic [WB-1:0]   mask_q;
  logic            inv_q;
  logic [WB-1:0]   cur_q;
  logic [PW-1:0]   res_pos_q;
  logic            res_found_q;
  logic            out_valid_q;
  logic [PW-1:0]   out_pos_q;
  logic            out_found_q;

  logic [bfb_pkg::START_W-1:0] eff_start;
  logic [WB-1:0]               cur;
  logic [WW:0]                 wnext;
  logic [AW+WW-1:0]            start_ext, next_ext;
  logic [AW+bfb_pkg::WIDX_W-1:0] widx_ext;
  logic                        wr_in_range;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_wa, mem_ra;
  logic [WB-1:0]               mem_wd;
  logic [PW-1:0]               hit_pos;
  logic                        hit_in;

  // Request decode
  assign eff_start = (opcode_i == bfb_pkg::OP_FIND_FIRST) ? '0 : start_offset_i;
  assign sts_o.is_write   = (opcode_i == bfb_pkg::OP_WRITE);
  assign sts_o.start_past = ({1'b0, eff_start} >= esz_q);
  assign wr_in_range      = (32'(word_index_i) < 32'(NUM_WORDS));

  // Scan state
  assign cur          = (rdata_q ^ {WB{inv_q}}) & mask_q;
  assign wnext        = {1'b0, wcnt_q} + 1'b1;
  assign sts_o.cur_nz = (cur != '0);
  assign sts_o.next_past = ({wnext, {OW{1'b0}}} >= {1'b0, esz_q});
  assign sts_o.clr_last  = (clr_cnt_q == LAST_ADDR);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Address extension to the memory depth
  assign start_ext = {{AW{1'b0}}, 1'b0, eff_start[bfb_pkg::START_W-1:OW]};
  assign next_ext  = {{AW{1'b0}}, wnext[WW-1:0]};
  assign widx_ext  = {{AW{1'b0}}, word_index_i};

  // Memory port selection
  always_comb begin
    mem_we = cmd_i.clr_we || (cmd_i.take && sts_o.is_write && wr_in_range);
    mem_wa = cmd_i.clr_we ? clr_cnt_q : widx_ext[AW-1:0];
    mem_wd = cmd_i.clr_we ? '0 : word_data_i;
    mem_re = cmd_i.rd_next || (cmd_i.take && !sts_o.is_write && !sts_o.start_past);
    mem_ra = cmd_i.rd_next ? next_ext[AW-1:0] : start_ext[AW-1:0];
  end

  // Bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Effective size, saturated to the bitmap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esz_q <= ESZ_RST;
    end else if (cfg_valid_i) begin
      esz_q <= (32'(cfg_bitmap_size_i) > TOTAL) ? PW'(TOTAL) : cfg_bitmap_size_i;
    end
  end

  // Scan pointer and word mask
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      wcnt_q <= {1'b0, eff_start[bfb_pkg::START_W-1:OW]};
      mask_q <= {WB{1'b1}} << eff_start[OW-1:0];
      inv_q  <= (opcode_i == bfb_pkg::OP_FIND_ZERO);
    end else if (cmd_i.rd_next) begin
      wcnt_q <= wnext[WW-1:0];
      mask_q <= {WB{1'b1}};
    end
    if (cmd_i.cur_load) cur_q <= cur;
  end

  // Bit resolution: word base plus trailing zeros, clamped to the size
  assign hit_pos = {wcnt_q, bfb_pkg::tz64(cur_q)};
  assign hit_in  = (hit_pos < esz_q);

  // Result holding register
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.take) begin
      res_pos_q   <= sts_o.is_write ? '0 : esz_q;
      res_found_q <= 1'b0;
    end else if (cmd_i.res_none) begin
      res_pos_q   <= esz_q;
      res_found_q <= 1'b0;
    end else if (cmd_i.res_hit) begin
      res_pos_q   <= hit_in ? hit_pos : esz_q;
      res_found_q <= hit_in;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pos_q   <= res_pos_q;
      out_found_q <= res_found_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bit_position_o = out_pos_q;
  assign found_o        = out_found_q;

endmodule

// ===== hdl/bfb_checker.sv =====
// ---------------------------------------------------------------------------
// bfb_checker
// Port-level checks for the find-bit engine, bound to the top level.
// ---------------------------------------------------------------------------
module bfb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [bfb_pkg::POS_W-1:0] cfg_bitmap_size_i,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [bfb_pkg::POS_W-1:0] bit_position_o,
  input logic                      found_o
);

  logic [bfb_pkg::POS_W-1:0] size_q;

  // Last written size, as seen on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= bfb_pkg::POS_W'(bfb_pkg::SIZE_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_bitmap_size_i;
    end
  end

  // A found bit lies below the size
  a_found_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> bit_position_o < size_q)
    else $error("found position not below size");

  // A miss never reports beyond the size
  a_miss_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> bit_position_o <= size_q)
    else $error("miss position beyond size");

  // One request at a time: intake closes after an acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted back to back");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(bit_position_o) && $stable(found_o))
    else $error("stalled result changed");

endmodule

bind bitmap_find_bit_engine_unit bfb_checker u_bfb_checker (.*);

// ===== tb/bitmap_find_bit_engine_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_find_bit_engine_checker
// Watches the configuration, request and result channels of the bitmap
// find-bit engine, keeps its own copy of the bitmap and size register,
// works out the expected bit position and found flag of every accepted
// request and compares each accepted result with the oldest expectation.
// ---------------------------------------------------------------------------
module bitmap_find_bit_engine_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bfb_pkg::POS_W-1:0]     cfg_bitmap_size_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [bfb_pkg::OP_W-1:0]      opcode_i,
  input  logic [bfb_pkg::WIDX_W-1:0]    word_index_i,
  input  logic [bfb_pkg::WORD_BITS-1:0] word_data_i,
  input  logic [bfb_pkg::START_W-1:0]   start_offset_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [bfb_pkg::POS_W-1:0]     bit_position_i,
  input  logic                          found_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);

  localparam int          WB        = bfb_pkg::WORD_BITS;
  localparam int          NW        = bfb_pkg::NUM_WORDS_DEF;
  localparam int          MAP_BITS  = NW * WB;
  localparam int unsigned SIZE_INIT = bfb_pkg::SIZE_RST;

  typedef struct packed {
    logic [bfb_pkg::POS_W-1:0] position;
    logic                      hit;
  } find_result_t;

  logic [WB-1:0]             map_words [NW];
  logic [bfb_pkg::POS_W-1:0] size_reg;
  find_result_t              awaited_q [$];

  // Index of the lowest set bit; only called on a non-zero word
  function automatic int unsigned lowest_set(input logic [WB-1:0] w);
    int unsigned n;
    n = 0;
    for (int i = WB - 1; i >= 0; i--)
      if (w[i]) n = i;
    return n;
  endfunction

  // Word-by-word scan from 'from', clamped to 'limit'
  function automatic int unsigned scan_map(input int unsigned limit,
                                           input int unsigned from,
                                           input logic        want_zero);
    int unsigned   pos;
    logic [WB-1:0] flip;
    logic [WB-1:0] cur;
    flip = {WB{want_zero}};
    if (from >= limit) return limit;
    pos = (from / WB) * WB;
    cur = (map_words[pos / WB] ^ flip) & ({WB{1'b1}} << (from % WB));
    while (cur == '0) begin
      pos += WB;
      if (pos >= limit) return limit;
      cur = map_words[pos / WB] ^ flip;
    end
    pos += lowest_set(cur);
    return (pos < limit) ? pos : limit;
  endfunction

  // Apply one request to the local bitmap and return its expected result
  function automatic find_result_t apply_request(
      input logic [bfb_pkg::OP_W-1:0]    op,
      input logic [bfb_pkg::WIDX_W-1:0]  idx,
      input logic [WB-1:0]               data,
      input logic [bfb_pkg::START_W-1:0] ofs);
    find_result_t res;
    int unsigned  limit;
    int unsigned  pos;
    limit = (32'(size_reg) < 32'(MAP_BITS)) ? 32'(size_reg) : 32'(MAP_BITS);
    res   = '0;
    case (op)
      bfb_pkg::OP_WRITE: begin
        if (32'(idx) < 32'(NW)) map_words[idx] = data;
        return res;
      end
      bfb_pkg::OP_FIND_FIRST: pos = scan_map(limit, 0, 1'b0);
      bfb_pkg::OP_FIND_SET:   pos = scan_map(limit, 32'(ofs), 1'b0);
      default:                pos = scan_map(limit, 32'(ofs), 1'b1);
    endcase
    res.position = pos[bfb_pkg::POS_W-1:0];
    res.hit      = (pos < limit);
    return res;
  endfunction

  // Channel monitor: results are matched before the new request is queued
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    find_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) map_words[i] = '0;
      size_reg = SIZE_INIT[bfb_pkg::POS_W-1:0];
      awaited_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) size_reg = cfg_bitmap_size_i;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual position %0d found %0b",
                   $time, bit_position_i, found_i);
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          if (bit_position_i !== want.position) begin
            $display("%0t: bit_position mismatch, expected %0d, actual %0d",
                     $time, want.position, bit_position_i);
            fail_count_o++;
          end
          if (found_i !== want.hit) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.hit, found_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_q.push_back(apply_request(opcode_i, word_index_i, word_data_i,
                                          start_offset_i));
      outstanding_o = awaited_q.size();
    end
  end

endmodule

// ===== tb/tb_bitmap_find_bit_engine_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bitmap_find_bit_engine_unit
// Drives word writes and find-first / find-next-set / find-next-zero
// requests into the bitmap find-bit engine over a range of bitmap sizes,
// with random gaps on the request side and random stalls on the result
// side. A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_bitmap_find_bit_engine_unit;

  localparam int MAP_BITS    = bfb_pkg::NUM_WORDS_DEF * bfb_pkg::WORD_BITS;
  localparam int QUIET_LIMIT = 5000;
  localparam int SEG_ITEMS   = 154;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bfb_pkg::POS_W-1:0]     cfg_size;
  logic                          in_valid;
  logic                          in_stall;
  logic [bfb_pkg::OP_W-1:0]      opcode;
  logic [bfb_pkg::WIDX_W-1:0]    word_index;
  logic [bfb_pkg::WORD_BITS-1:0] word_data;
  logic [bfb_pkg::START_W-1:0]   start_offset;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bfb_pkg::POS_W-1:0]     bit_position;
  logic                          found;
  int                            fail_count;
  int                            outstanding;
  int                            quiet_cycles = 0;

  // idling percentages and the size last written to the block
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned cur_size  = bfb_pkg::SIZE_RST;

  always #5ns clk = ~clk;

  bitmap_find_bit_engine_unit u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_bitmap_size_i (cfg_size),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .word_index_i      (word_index),
    .word_data_i       (word_data),
    .start_offset_i    (start_offset),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .bit_position_o    (bit_position),
    .found_o           (found)
  );

  bitmap_find_bit_engine_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_bitmap_size_i (cfg_size),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .opcode_i          (opcode),
    .word_index_i      (word_index),
    .word_data_i       (word_data),
    .start_offset_i    (start_offset),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .bit_position_i    (bit_position),
    .found_i           (found),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding)
  );

  // Result side back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: ends the run after too long without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("** bitmap_find_bit_engine_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until accepted; entered at a falling edge
  task automatic send_request(input logic [bfb_pkg::OP_W-1:0]      op,
                              input logic [bfb_pkg::WIDX_W-1:0]    idx,
                              input logic [bfb_pkg::WORD_BITS-1:0] data,
                              input logic [bfb_pkg::START_W-1:0]   ofs);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    word_index   <= idx;
    word_data    <= data;
    start_offset <= ofs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Size register write, only with the block idle
  task automatic set_size(input int unsigned value);
    drain();
    cfg_valid <= 1'b1;
    cfg_size  <= value[bfb_pkg::POS_W-1:0];
    cur_size   = 32'(value[bfb_pkg::POS_W-1:0]);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Word contents; dense maps lean towards all-ones, sparse towards zero
  function automatic logic [bfb_pkg::WORD_BITS-1:0] pick_word(input bit dense);
    logic [bfb_pkg::WORD_BITS-1:0] w;
    int unsigned                   r;
    r = $urandom_range(99);
    w = {$urandom, $urandom};
    if (r < 55)
      w = dense ? '1 : '0;
    else if (r < 67)
      w = dense ? ~(64'd1 << $urandom_range(63)) : (64'd1 << $urandom_range(63));
    else if (r < 75)
      w = dense ? '0 : '1;
    else if (r < 87)
      w = dense ? (w | {$urandom, $urandom} | {$urandom, $urandom})
                : (w & {$urandom, $urandom} & {$urandom, $urandom});
    return w;
  endfunction

  // Start offsets: inside the size, around it, on word edges, or anywhere
  function automatic logic [bfb_pkg::START_W-1:0] pick_offset(input int unsigned limit);
    int          ofs;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40 && limit > 0)
      ofs = int'($urandom_range(limit - 1));
    else if (r < 60)
      ofs = int'(limit) + int'($urandom_range(2)) - 1;
    else if (r < 80)
      ofs = int'($urandom_range(63)) * bfb_pkg::WORD_BITS + int'($urandom_range(2)) - 1;
    else
      ofs = int'($urandom_range(4095));
    if (ofs < 0) ofs = 0;
    return ofs[bfb_pkg::START_W-1:0];
  endfunction

  // One stretch of random requests at the current size
  task automatic run_segment(input int count, input bit dense);
    logic [bfb_pkg::OP_W-1:0]   op;
    logic [bfb_pkg::WIDX_W-1:0] idx;
    int unsigned                r;
    int unsigned                limit;
    limit = (cur_size < MAP_BITS) ? cur_size : MAP_BITS;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 35)      op = bfb_pkg::OP_WRITE;
      else if (r < 50) op = bfb_pkg::OP_FIND_FIRST;
      else if (r < 75) op = bfb_pkg::OP_FIND_SET;
      else             op = bfb_pkg::OP_FIND_ZERO;
      r   = $urandom_range(63);
      idx = r[bfb_pkg::WIDX_W-1:0];
      send_request(op, idx, pick_word(dense), pick_offset(limit));
      // occasional full pause mid-stream
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  // Hand-picked requests covering the corner cases
  task automatic run_directed();
    // empty map at the reset size
    send_request(bfb_pkg::OP_FIND_FIRST, '0, '0, '0);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, '0);
    send_request(bfb_pkg::OP_FIND_ZERO, '0, '0, 12'd4095);
    // only the very last bit set
    send_request(bfb_pkg::OP_WRITE, 6'd63, 64'h8000_0000_0000_0000, '1);
    send_request(bfb_pkg::OP_FIND_FIRST, '0, '0, '0);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd4095);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd100);
    // first word full
    send_request(bfb_pkg::OP_WRITE, '0, '1, '0);
    send_request(bfb_pkg::OP_FIND_ZERO, '0, '0, '0);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd63);
    send_request(bfb_pkg::OP_FIND_FIRST, '1, '1, '1);
    // size beyond the map saturates to the map
    set_size(8191);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd4032);
    send_request(bfb_pkg::OP_FIND_ZERO, '0, '0, 12'd4095);
    // zero size: nothing is ever found
    set_size(0);
    send_request(bfb_pkg::OP_FIND_FIRST, '0, '0, '0);
    send_request(bfb_pkg::OP_FIND_ZERO, '0, '0, '0);
    // clear bits past the size in the last word, start at or past the size
    set_size(100);
    send_request(bfb_pkg::OP_WRITE, 6'd1, 64'h0000_000F_FFFF_FFFF, '0);
    send_request(bfb_pkg::OP_FIND_ZERO, '0, '0, 12'd64);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd100);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd4095);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd99);
    send_request(bfb_pkg::OP_WRITE, 6'd1, '0, 12'hfff);
    send_request(bfb_pkg::OP_FIND_SET, '0, '0, 12'd70);
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned seg_sizes [12];
    int unsigned sz;
    seg_sizes = '{4096, 8191, 65, 4095, 1, 64, 2000, 63, 0, 4097, 777, 4096};
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_size     = '0;
    in_valid     = 1'b0;
    opcode       = bfb_pkg::OP_WRITE;
    word_index   = '0;
    word_data    = '0;
    start_offset = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_pct   = 10;
    stall_pct = 66;
    run_directed();

    // receiver idles heavily first, then the sender, then neither
    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        gap_pct   = 66;
        stall_pct = 10;
      end else if (seg == 8) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      sz = (seg == 10) ? $urandom_range(8191) : seg_sizes[seg];
      set_size(sz);
      run_segment(SEG_ITEMS, seg[0]);
    end

    drain();
    repeat (20) @(negedge clk);
    if (outstanding != 0)
      $display("%0t: %0d results never arrived", $time, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** bitmap_find_bit_engine_unit: PASSED **");
    end else begin
      $display("** bitmap_find_bit_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bfb_pkg.sv
hdl/bfb_ctrl.sv
hdl/bfb_dpath.sv
hdl/bitmap_find_bit_engine_unit.sv
hdl/bfb_checker.sv
tb/bitmap_find_bit_engine_checker.sv
tb/tb_bitmap_find_bit_engine_unit.sv
